// File: rtl/b64_pkg.sv
// Shared types, constants and alphabet functions for the Base64 codec.
package b64_pkg;

	localparam int MAX_RESULTS = 5;

	localparam logic [7:0] PAD_CHAR   = 8'h3D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	localparam logic [1:0] HELD_TWO = 2'd2;

	typedef enum logic [1:0] {
		KIND_DATA    = 2'd0,
		KIND_END_OK  = 2'd1,
		KIND_END_ERR = 2'd2
	} kind_t;

	// results produced by one input word, slot 0 first
	typedef struct packed {
		logic [2:0]                         count;
		logic [MAX_RESULTS-1:0][7:0]        value;
		kind_t [MAX_RESULTS-1:0]            kind;
	} job_t;

	typedef struct packed {
		logic       valid;
		logic [5:0] value;
	} sextet_t;

	function automatic logic [7:0] enc_char(input logic [5:0] s);
		logic [7:0] c;
		if (s < 6'd26) begin
			c = 8'h41 + {2'b00, s};
		end else if (s < 6'd52) begin
			c = 8'h61 + {2'b00, s - 6'd26};
		end else if (s < 6'd62) begin
			c = 8'h30 + {2'b00, s - 6'd52};
		end else if (s == 6'd62) begin
			c = 8'h2D;
		end else begin
			c = 8'h5F;
		end
		return c;
	endfunction

	// accept both the URL-safe and the standard alphabet
	function automatic sextet_t dec_char(input logic [7:0] c);
		sextet_t r;
		r.valid = 1'b1;
		r.value = 6'd0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r.value = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			r.value = 6'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r.value = 6'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2D || c == 8'h2B) begin
			r.value = 6'd62;
		end else if (c == 8'h5F || c == 8'h2F) begin
			r.value = 6'd63;
		end else begin
			r.valid = 1'b0;
		end
		return r;
	endfunction

endpackage

// File: rtl/b64_front.sv
// Front end: takes input words, keeps the stream state and builds one job per word.
module b64_front import b64_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       accept,
	input  logic [7:0] in_value,
	input  logic       in_last,
	output logic       mode,
	output job_t       job
);

	logic        mode_q;
	logic [15:0] held_q;
	logic [1:0]  held_cnt_q;
	logic [12:0] acc_q;
	logic [2:0]  bc_q;
	logic        err_q;

	logic [15:0] held_d;
	logic [1:0]  held_cnt_d;
	logic [12:0] acc_d;
	logic [2:0]  bc_d;
	logic        err_d;

	logic [23:0] grp;
	logic        skip;
	sextet_t     sx;
	logic [3:0]  bsum;
	logic        have_byte;
	logic [7:0]  dec_byte;

	assign mode = mode_q;

	always_comb begin
		held_d     = held_q;
		held_cnt_d = held_cnt_q;
		acc_d      = acc_q;
		bc_d       = bc_q;
		err_d      = err_q;
		grp        = '0;
		have_byte  = 1'b0;
		dec_byte   = '0;
		bsum       = '0;
		job.count  = '0;
		job.value  = '0;
		job.kind   = {MAX_RESULTS{KIND_DATA}};
		skip = (in_value == PAD_CHAR) || (in_value == CHAR_LF) ||
			(in_value == CHAR_CR) || (in_value == CHAR_SPACE);
		sx = dec_char(in_value);

		if (!mode_q) begin
			if (held_cnt_q >= HELD_TWO) begin
				grp = {held_q, in_value};
				job.value[0] = enc_char(grp[23:18]);
				job.value[1] = enc_char(grp[17:12]);
				job.value[2] = enc_char(grp[11:6]);
				job.value[3] = enc_char(grp[5:0]);
				job.count    = 3'd4;
				held_d       = '0;
				held_cnt_d   = '0;
				if (in_last) begin
					job.kind[4] = KIND_END_OK;
					job.count   = 3'd5;
				end
			end else begin
				held_d     = {held_q[7:0], in_value};
				held_cnt_d = held_cnt_q + 2'd1;
				if (in_last) begin
					// flush the partial group with padding
					if (held_cnt_d == 2'd1) begin
						grp = {held_d[7:0], 16'h0000};
						job.value[0] = enc_char(grp[23:18]);
						job.value[1] = enc_char(grp[17:12]);
						job.value[2] = PAD_CHAR;
					end else begin
						grp = {held_d, 8'h00};
						job.value[0] = enc_char(grp[23:18]);
						job.value[1] = enc_char(grp[17:12]);
						job.value[2] = enc_char(grp[11:6]);
					end
					job.value[3] = PAD_CHAR;
					job.kind[4]  = KIND_END_OK;
					job.count    = 3'd5;
				end
			end
		end else begin
			if (!skip && !err_q) begin
				if (!sx.valid) begin
					err_d = 1'b1;
				end else begin
					acc_d = {acc_q[6:0], sx.value};
					bsum  = {1'b0, bc_q} + 4'd6;
					if (bsum >= 4'd8) begin
						bc_d      = 3'(bsum - 4'd8);
						dec_byte  = 8'(acc_d >> bc_d);
						have_byte = 1'b1;
					end else begin
						bc_d = bsum[2:0];
					end
				end
			end
			if (have_byte) begin
				job.value[0] = dec_byte;
				job.count    = 3'd1;
			end
			if (in_last) begin
				if (have_byte) begin
					job.kind[1] = err_d ? KIND_END_ERR : KIND_END_OK;
					job.count   = 3'd2;
				end else begin
					job.kind[0] = err_d ? KIND_END_ERR : KIND_END_OK;
					job.count   = 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b0;
			held_q     <= '0;
			held_cnt_q <= '0;
			acc_q      <= '0;
			bc_q       <= '0;
			err_q      <= 1'b0;
		end else if (cfg_we) begin
			// drop any partial stream
			mode_q     <= cfg_wdata;
			held_q     <= '0;
			held_cnt_q <= '0;
			acc_q      <= '0;
			bc_q       <= '0;
			err_q      <= 1'b0;
		end else if (accept) begin
			if (in_last) begin
				held_q     <= '0;
				held_cnt_q <= '0;
				acc_q      <= '0;
				bc_q       <= '0;
				err_q      <= 1'b0;
			end else begin
				held_q     <= held_d;
				held_cnt_q <= held_cnt_d;
				acc_q      <= acc_d;
				bc_q       <= bc_d;
				err_q      <= err_d;
			end
		end
	end

endmodule

// File: rtl/b64_queue.sv
// Job queue between the front end and the result serialiser.
module b64_queue import b64_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t head,
	output logic empty,
	output logic full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign head  = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/b64_back.sv
// Back end: walks the head job out one result word per cycle while m_ready is high.
module b64_back import b64_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  job_t       head,
	input  logic       head_valid,
	output logic       pop,
	output logic       m_valid,
	input  logic       m_ready,
	output logic [7:0] m_value,
	output logic [1:0] m_kind,
	output logic       m_last
);

	logic [2:0] idx_q;
	logic       fire;

	assign m_valid = head_valid;
	assign m_value = head.value[idx_q];
	assign m_kind  = head.kind[idx_q];
	assign m_last  = (idx_q == head.count - 3'd1);
	assign fire    = m_valid && m_ready;
	assign pop     = fire && m_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (fire) begin
			// advance within the job, rewind once it is done
			idx_q <= m_last ? 3'd0 : idx_q + 3'd1;
		end
	end

endmodule

// File: rtl/base64_url_codec.sv
// Top level: streaming Base64 codec, URL-safe encode and dual-alphabet decode.
// The first result of a word is offered once its job has been registered in the job queue,
// later when the results of jobs already queued ahead of it are still leaving.
// Throughput: one input word per cycle while the job queue has room; results leave at
// one word per cycle while m_axis_tready is high, so a stream runs at the pace of its
// results (encode gives four results per three bytes, up to five on a closing byte).
// Reset: arst_n clears the mode to encode, all stream state and the job queue.
module base64_url_codec import b64_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] in_value
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] out_value
	output logic [1:0] m_axis_tuser,  // [1:0] out_kind
	output logic       m_axis_tlast
);

	logic accept;
	logic push;
	logic pop;
	logic q_empty;
	logic q_full;
	logic mode;
	job_t new_job;
	job_t head_job;

	assign s_axis_tready = !q_full;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign push          = accept && (new_job.count != 3'd0);

	b64_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.in_value  (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.mode      (mode),
		.job       (new_job)
	);

	b64_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (new_job),
		.pop      (pop),
		.head     (head_job),
		.empty    (q_empty),
		.full     (q_full)
	);

	b64_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head_job),
		.head_valid (!q_empty),
		.pop        (pop),
		.m_valid    (m_axis_tvalid),
		.m_ready    (m_axis_tready),
		.m_value    (m_axis_tdata),
		.m_kind     (m_axis_tuser),
		.m_last     (m_axis_tlast)
	);

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("job queue written while full");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != KIND_DATA) |-> m_axis_tlast)
		else $error("stream end word without tlast");

	a_encode_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !mode) |-> (m_axis_tuser != KIND_END_ERR))
		else $error("decode error reported in encode mode");

	a_pop_empties_job: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push && q_full) |=> !q_full)
		else $error("queue stayed full after a pop");
`endif

endmodule
